### rtl/core/pvs_pkg.sv
package pvs_pkg;

    // item operation codes
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_COMMAND = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_LOW_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_HIGH_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_BAT_THRESHOLD = 2'd2;
    localparam logic [1:0] CFG_OFF_DELAY     = 2'd3;

    // configuration reset values and limits
    localparam logic [12:0] LOW_THRESHOLD_RST = 13'd500;
    localparam logic [15:0] HIGH_LIMIT_RST    = 16'd14000;
    localparam logic [15:0] BAT_THRESHOLD_RST = 16'd9000;
    localparam logic [15:0] OFF_DELAY_RST     = 16'd2000;
    localparam logic [15:0] LOW_MIN           = 16'd500;
    localparam logic [15:0] LOW_MAX           = 16'd6000;

    // duty values
    localparam logic [6:0] DUTY_ON  = 7'd50;
    localparam logic [6:0] DUTY_MAX = 7'd100;
    localparam logic [7:0] STATUS_DUTY_FLAG = 8'h80;

    // command byte bits
    localparam int CMD_DUTY_BIT   = 7;
    localparam int CMD_MANUAL_BIT = 5;
    localparam int CMD_MOTOR_BIT  = 4;
    localparam int CMD_V1_BIT     = 3;
    localparam int CMD_V1_EXT_BIT = 2;
    localparam int CMD_V2_BIT     = 1;
    localparam int CMD_V2_EXT_BIT = 0;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] battery_sample;
        logic [15:0] cr1_sample;
        logic [15:0] cr2_sample;
        logic [7:0]  command_byte;
    } pvs_in_t;

    typedef struct packed {
        logic [15:0] status_word;
        logic        motor_on;
        logic        valve1_on;
        logic        valve1_ext_on;
        logic        valve2_on;
        logic        valve2_ext_on;
        logic [6:0]  duty_out;
    } pvs_out_t;

endpackage

### rtl/core/pump_valve_sequencer.sv
// Pump and valve sequencer. Each transfer on the s_ channel (sample set, manual command or
// millisecond tick) yields exactly one status transfer on the m_ channel, taken after the
// item is applied. An item passes through the input register and then the result register,
// and one item is accepted every cycle; the only limit is the result register, which the
// block refills as soon as m_ready takes it. Configuration writes on cfg_we take effect at
// the next clock edge and should only be issued while idle.
module pump_valve_sequencer #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  pvs_pkg::pvs_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pvs_pkg::pvs_out_t  m_data
);
    import pvs_pkg::*;

    localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    // configuration registers
    logic [12:0] low_threshold_reg;
    logic [15:0] high_limit_reg;
    logic [15:0] bat_threshold_reg;
    logic [15:0] off_delay_reg;

    // pipeline registers
    logic     in_valid_reg;
    pvs_in_t  in_data_reg;
    logic     out_valid_reg;
    pvs_out_t out_data_reg;

    // sequencer state
    logic        auto_enabled_reg,   auto_enabled_next;
    logic        battery_active_reg, battery_active_next;
    logic        cr1_active_reg,     cr1_active_next;
    logic        cr2_active_reg,     cr2_active_next;
    logic        motor_drive_reg,    motor_drive_next;
    logic        valve1_reg,         valve1_next;
    logic        valve1_ext_reg,     valve1_ext_next;
    logic        valve2_reg,         valve2_next;
    logic        valve2_ext_reg,     valve2_ext_next;
    logic [6:0]  duty_cycle_reg,     duty_cycle_next;
    logic [15:0] off_countdown_reg,  off_countdown_next;
    logic        off_timer_running_reg, off_timer_running_next;

    logic     advance;
    pvs_out_t result;
    logic [15:0] bat_s, c1_s, c2_s;
    logic     f1, f2;
    logic [7:0] status_hi, status_lo;

    // handshake: input stage moves when the result register is free or being taken
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_threshold_reg <= LOW_THRESHOLD_RST;
            high_limit_reg    <= HIGH_LIMIT_RST;
            bat_threshold_reg <= BAT_THRESHOLD_RST;
            off_delay_reg     <= OFF_DELAY_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LOW_THRESHOLD: begin
                    if (cfg_wdata >= LOW_MIN && cfg_wdata <= LOW_MAX) begin
                        low_threshold_reg <= cfg_wdata[12:0];
                    end
                end
                CFG_HIGH_LIMIT:    high_limit_reg    <= cfg_wdata;
                CFG_BAT_THRESHOLD: bat_threshold_reg <= cfg_wdata;
                CFG_OFF_DELAY:     off_delay_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // masked samples and channel detect
    assign bat_s = in_data_reg.battery_sample & SAMPLE_MASK;
    assign c1_s  = in_data_reg.cr1_sample & SAMPLE_MASK;
    assign c2_s  = in_data_reg.cr2_sample & SAMPLE_MASK;
    assign f1 = (c1_s > {3'b000, low_threshold_reg}) && (c1_s < high_limit_reg);
    assign f2 = (c2_s > {3'b000, low_threshold_reg}) && (c2_s < high_limit_reg);

    // item processing
    always_comb begin
        auto_enabled_next      = auto_enabled_reg;
        battery_active_next    = battery_active_reg;
        cr1_active_next        = cr1_active_reg;
        cr2_active_next        = cr2_active_reg;
        motor_drive_next       = motor_drive_reg;
        valve1_next            = valve1_reg;
        valve1_ext_next        = valve1_ext_reg;
        valve2_next            = valve2_reg;
        valve2_ext_next        = valve2_ext_reg;
        duty_cycle_next        = duty_cycle_reg;
        off_countdown_next     = off_countdown_reg;
        off_timer_running_next = off_timer_running_reg;
        case (in_data_reg.op)
            OP_SAMPLE: begin
                if (bat_s >= bat_threshold_reg) begin
                    battery_active_next = 1'b1;
                    auto_enabled_next   = 1'b0;
                    motor_drive_next    = 1'b1;
                    duty_cycle_next     = DUTY_ON;
                end else begin
                    // battery removed: drop duty and motor first
                    if (battery_active_reg) begin
                        duty_cycle_next  = '0;
                        motor_drive_next = 1'b0;
                    end
                    battery_active_next = 1'b0;
                    auto_enabled_next   = 1'b1;
                    // two-channel detect rules
                    if (f1 && f2) begin
                        valve2_ext_next  = 1'b0;
                        valve1_ext_next  = 1'b0;
                        motor_drive_next = 1'b1;
                        duty_cycle_next  = DUTY_ON;
                    end else if (f1) begin
                        if (!cr1_active_reg) begin
                            valve2_ext_next = 1'b1;
                            if (!cr2_active_reg) begin
                                motor_drive_next = 1'b1;
                                duty_cycle_next  = DUTY_ON;
                            end
                            cr1_active_next = 1'b1;
                        end
                        if (cr2_active_reg) begin
                            valve1_ext_next = 1'b0;
                            cr2_active_next = 1'b0;
                        end
                    end else if (f2) begin
                        if (!cr2_active_reg) begin
                            valve1_ext_next = 1'b1;
                            if (!cr1_active_reg) begin
                                motor_drive_next = 1'b1;
                                duty_cycle_next  = DUTY_ON;
                            end
                            cr2_active_next = 1'b1;
                        end
                        if (cr1_active_reg) begin
                            valve2_ext_next = 1'b0;
                            cr1_active_next = 1'b0;
                        end
                    end else begin
                        // both channels gone: arm the motor-off countdown
                        if (cr1_active_reg) begin
                            valve2_ext_next = 1'b0;
                        end
                        if (cr2_active_reg) begin
                            valve1_ext_next = 1'b0;
                        end
                        if (cr1_active_reg || cr2_active_reg) begin
                            duty_cycle_next        = '0;
                            off_countdown_next     = off_delay_reg;
                            off_timer_running_next = 1'b1;
                        end
                        cr1_active_next = 1'b0;
                        cr2_active_next = 1'b0;
                    end
                end
            end
            OP_COMMAND: begin
                if (in_data_reg.command_byte[CMD_DUTY_BIT]) begin
                    duty_cycle_next = in_data_reg.command_byte[6:0];
                end else begin
                    auto_enabled_next = !in_data_reg.command_byte[CMD_MANUAL_BIT];
                    motor_drive_next  = in_data_reg.command_byte[CMD_MOTOR_BIT];
                    valve1_next       = in_data_reg.command_byte[CMD_V1_BIT];
                    valve1_ext_next   = in_data_reg.command_byte[CMD_V1_EXT_BIT];
                    valve2_next       = in_data_reg.command_byte[CMD_V2_BIT];
                    valve2_ext_next   = in_data_reg.command_byte[CMD_V2_EXT_BIT];
                end
            end
            OP_TICK: begin
                if (off_timer_running_reg) begin
                    if (off_countdown_reg <= 16'd1) begin
                        off_countdown_next     = '0;
                        off_timer_running_next = 1'b0;
                        if (!cr1_active_reg && !cr2_active_reg) begin
                            motor_drive_next = 1'b0;
                        end
                    end else begin
                        off_countdown_next = off_countdown_reg - 16'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // status word from the updated state
    always_comb begin
        status_lo = {2'b00, auto_enabled_next, motor_drive_next, valve1_next,
                     valve1_ext_next, valve2_next, valve2_ext_next};
        if (duty_cycle_next != '0 && duty_cycle_next <= DUTY_MAX) begin
            status_hi = STATUS_DUTY_FLAG | {1'b0, duty_cycle_next};
        end else begin
            status_hi = '0;
        end
        result.status_word   = {status_hi, status_lo};
        result.motor_on      = motor_drive_next;
        result.valve1_on     = valve1_next;
        result.valve1_ext_on = valve1_ext_next;
        result.valve2_on     = valve2_next;
        result.valve2_ext_on = valve2_ext_next;
        result.duty_out      = duty_cycle_next;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    // state update once per processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_enabled_reg      <= 1'b1;
            battery_active_reg    <= 1'b0;
            cr1_active_reg        <= 1'b0;
            cr2_active_reg        <= 1'b0;
            motor_drive_reg       <= 1'b0;
            valve1_reg            <= 1'b0;
            valve1_ext_reg        <= 1'b0;
            valve2_reg            <= 1'b0;
            valve2_ext_reg        <= 1'b0;
            duty_cycle_reg        <= '0;
            off_countdown_reg     <= '0;
            off_timer_running_reg <= 1'b0;
        end else if (advance) begin
            auto_enabled_reg      <= auto_enabled_next;
            battery_active_reg    <= battery_active_next;
            cr1_active_reg        <= cr1_active_next;
            cr2_active_reg        <= cr2_active_next;
            motor_drive_reg       <= motor_drive_next;
            valve1_reg            <= valve1_next;
            valve1_ext_reg        <= valve1_ext_next;
            valve2_reg            <= valve2_next;
            valve2_ext_reg        <= valve2_ext_next;
            duty_cycle_reg        <= duty_cycle_next;
            off_countdown_reg     <= off_countdown_next;
            off_timer_running_reg <= off_timer_running_next;
        end
    end

    // idle countdown is always cleared
    a_timer_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !off_timer_running_reg |-> off_countdown_reg == '0)
        else $error("countdown non-zero while timer stopped");

    // at most one channel flag is held
    a_channels_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cr1_active_reg && cr2_active_reg))
        else $error("both channel flags set");

    // a pending item is not lost while the result stalls
    a_pending_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg && out_valid_reg)
        else $error("pending item dropped under stall");

    // status motor bit follows the motor output
    a_status_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_data_reg.status_word[4] == out_data_reg.motor_on)
        else $error("status motor bit mismatch");

endmodule
